// ===== hw/rtl/ppc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_pkg
// Types and constants shared by the polygon point containment block.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int MAX_VERTICES = 64;

    localparam int COORD_W  = 24;
    localparam int RADIUS_W = 24;
    localparam int ANGLE_W  = 16;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int REQ_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [REQ_W-1:0] REQ_APPEND     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE_LAST = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE_AT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ANGLE = 2'd2;

    localparam int TRIG_W  = 32;
    localparam int ZACC_W  = 26;
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [ANGLE_W-1:0]  angle;
    } t_vertex;

    function automatic logic signed [ZACC_W-1:0] cordic_atan(input logic [3:0] step);
        logic signed [ZACC_W-1:0] v;
        case (step)
            4'd0:  v = 26'sd2097152;
            4'd1:  v = 26'sd1238021;
            4'd2:  v = 26'sd654136;
            4'd3:  v = 26'sd332053;
            4'd4:  v = 26'sd166669;
            4'd5:  v = 26'sd83416;
            4'd6:  v = 26'sd41718;
            4'd7:  v = 26'sd20860;
            4'd8:  v = 26'sd10430;
            4'd9:  v = 26'sd5215;
            4'd10: v = 26'sd2608;
            4'd11: v = 26'sd1304;
            4'd12: v = 26'sd652;
            4'd13: v = 26'sd326;
            4'd14: v = 26'sd163;
            4'd15: v = 26'sd81;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ppc_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_req_if
// Request channel: vertex table edits and point queries.
// ----------------------------------------------------------------------------
interface ppc_req_if import ppc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [REQ_W-1:0]           req_type;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic [RADIUS_W-1:0]        vertex_radius;
    logic [ANGLE_W-1:0]         vertex_angle;
    logic [INDEX_W-1:0]         vertex_index;

    modport source (output valid, req_type, point_x, point_y, vertex_radius,
                    vertex_angle, vertex_index, input ready);
    modport sink (input valid, req_type, point_x, point_y, vertex_radius,
                  vertex_angle, vertex_index, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ppc_res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_res_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
interface ppc_res_if import ppc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               inside_res;
    logic               status;
    logic [COUNT_W-1:0] vertex_count;

    modport source (output valid, inside_res, status, vertex_count, input ready);
    modport sink (input valid, inside_res, status, vertex_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ppc_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface ppc_cfg_if import ppc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink (input valid, wr_index, wr_data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ppc_vmem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_vmem
// Vertex table memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ppc_vmem import ppc_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_vertex       i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_vertex            o_rd_data
);

    t_vertex r_mem [DEPTH];
    t_vertex r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== hw/rtl/ppc_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_cordic
// Iterative rotation unit giving cosine and sine of a 16-bit angle in Q30.
// ----------------------------------------------------------------------------
module ppc_cordic import ppc_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [ANGLE_W-1:0]       i_angle,
    output logic                          o_done,
    output logic signed [TRIG_W-1:0]      o_cos,
    output logic signed [TRIG_W-1:0]      o_sin
);

    logic                      r_busy;
    logic                      r_done;
    logic                      r_flip;
    logic [3:0]                r_i;
    logic signed [TRIG_W-1:0]  r_x;
    logic signed [TRIG_W-1:0]  r_y;
    logic signed [ZACC_W-1:0]  r_z;

    logic                      w_fold;
    logic [ANGLE_W-1:0]        w_a;
    logic signed [TRIG_W-1:0]  w_xs;
    logic signed [TRIG_W-1:0]  w_ys;
    logic signed [ZACC_W-1:0]  w_atan;

    assign w_fold = (i_angle >= 16'd16384) && (i_angle < 16'd49152);
    assign w_a    = w_fold ? (i_angle + 16'd32768) : i_angle;
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = cordic_atan(r_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= r_busy && (r_i == 4'(CORDIC_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_i <= r_i + 4'd1;
                if (r_i == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= w_fold;
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= ZACC_W'(signed'({w_a, 8'b0}));
        end else if (r_busy) begin
            if (!r_z[ZACC_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule
`default_nettype wire

// ===== hw/rtl/polar_polygon_point_containment_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polar_polygon_point_containment_top
// Even-odd point containment test over a polygon stored in polar form.
// ----------------------------------------------------------------------------
// One request is handled at a time; a finished result waits in an output
// register while the next request is taken. Append, remove last and any
// rejected request go straight to the result. Remove at index moves the
// later vertices down through the vertex memory, one read and one write
// per vertex moved. A query compares the squared distance of the point
// from the centre with the squared largest radius and ends when the point
// lies beyond it. Otherwise it converts count + 1 vertices, the closing
// vertex first, and tests each edge that crosses the ray. Each vertex goes
// through the 16-step iterative rotation unit, then the shared multiplier
// for the Cartesian and edge terms.
// ----------------------------------------------------------------------------
module polar_polygon_point_containment_top import ppc_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ppc_req_if.sink     i_req,
    ppc_res_if.source   o_res,
    ppc_cfg_if.sink     i_cfg
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int MW = 33;
    localparam int PW = 2 * MW;
    localparam int VW = 28;
    localparam int SW = 58;

    typedef enum logic [16:0] {
        S_IDLE     = 17'b00000000000000001,
        S_SHIFT_RD = 17'b00000000000000010,
        S_SHIFT_WR = 17'b00000000000000100,
        S_FAR_DX   = 17'b00000000000001000,
        S_FAR_DY   = 17'b00000000000010000,
        S_FAR_RR   = 17'b00000000000100000,
        S_V_RD     = 17'b00000000001000000,
        S_V_TRIG   = 17'b00000000010000000,
        S_V_WAIT   = 17'b00000000100000000,
        S_V_MULX   = 17'b00000001000000000,
        S_V_CVTX   = 17'b00000010000000000,
        S_V_CVTY   = 17'b00000100000000000,
        S_EDGE_CHK = 17'b00001000000000000,
        S_EDGE_L   = 17'b00010000000000000,
        S_EDGE_R   = 17'b00100000000000000,
        S_STEP     = 17'b01000000000000000,
        S_DONE     = 17'b10000000000000000
    } t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_count;
    logic [RADIUS_W-1:0]        r_largest;
    logic signed [COORD_W-1:0]  r_cx;
    logic signed [COORD_W-1:0]  r_cy;
    logic [ANGLE_W-1:0]         r_base;
    logic signed [COORD_W-1:0]  r_px;
    logic signed [COORD_W-1:0]  r_py;
    logic [CW-1:0]              r_k;
    logic                       r_first;
    logic                       r_in;
    logic                       r_inside;
    logic                       r_status;
    logic [50:0]                r_acc;
    logic [RADIUS_W-1:0]        r_rad;
    logic signed [TRIG_W-1:0]   r_cos;
    logic signed [TRIG_W-1:0]   r_sin;
    logic signed [SW-1:0]       r_prod;
    logic signed [VW-1:0]       r_vx;
    logic signed [VW-1:0]       r_vy;
    logic signed [VW-1:0]       r_ox;
    logic signed [VW-1:0]       r_oy;
    logic signed [SW-1:0]       r_lhs;
    logic                       r_out_valid;
    logic                       r_out_inside;
    logic                       r_out_status;
    logic [COUNT_W-1:0]         r_out_count;

    logic                       w_req_acc;
    logic [CW+INDEX_W-1:0]      w_idx_ext;
    logic [CW+INDEX_W-1:0]      w_cnt_ext;
    logic [CW+COUNT_W-1:0]      w_cnt_out;
    logic [CW-1:0]              w_last;
    logic signed [COORD_W:0]    w_dx;
    logic signed [COORD_W:0]    w_dy;
    logic signed [VW-1:0]       w_pxv;
    logic signed [VW-1:0]       w_pyv;
    logic signed [VW:0]         w_d;
    logic signed [MW-1:0]       w_ma;
    logic signed [MW-1:0]       w_mb;
    logic signed [PW-1:0]       w_prod;
    logic signed [SW-1:0]       w_sum;
    logic signed [19:0]         w_q;
    logic signed [VW-1:0]       w_v;
    logic                       w_cross;
    logic                       w_hit;

    logic                       w_wr_en;
    logic [AW-1:0]              w_wr_addr;
    t_vertex                    w_wr_data;
    logic                       w_rd_en;
    logic [AW-1:0]              w_rd_addr;
    t_vertex                    w_rd_data;
    logic                       w_cordic_start;
    logic                       w_cordic_done;
    logic signed [TRIG_W-1:0]   w_cos;
    logic signed [TRIG_W-1:0]   w_sin;

    ppc_vmem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_vmem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    ppc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cordic_start),
        .i_angle (w_rd_data.angle + r_base),
        .o_done  (w_cordic_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_req_acc   = i_req.valid && i_req.ready;

    assign w_idx_ext = {{CW{1'b0}}, i_req.vertex_index};
    assign w_cnt_ext = {{INDEX_W{1'b0}}, r_count};
    assign w_cnt_out = {{COUNT_W{1'b0}}, r_count};
    assign w_last    = r_count - CW'(1);

    assign w_dx  = (COORD_W + 1)'(r_px) - (COORD_W + 1)'(r_cx);
    assign w_dy  = (COORD_W + 1)'(r_py) - (COORD_W + 1)'(r_cy);
    assign w_pxv = VW'(r_px);
    assign w_pyv = VW'(r_py);
    assign w_d   = (VW + 1)'(r_oy) - (VW + 1)'(r_vy);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_FAR_DX: begin
                w_ma = MW'(w_dx);
                w_mb = MW'(w_dx);
            end
            S_FAR_DY: begin
                w_ma = MW'(w_dy);
                w_mb = MW'(w_dy);
            end
            S_FAR_RR: begin
                w_ma = signed'(MW'(r_largest));
                w_mb = signed'(MW'(r_largest));
            end
            S_V_MULX: begin
                w_ma = signed'(MW'(r_rad));
                w_mb = MW'(r_cos);
            end
            S_V_CVTX: begin
                w_ma = signed'(MW'(r_rad));
                w_mb = MW'(r_sin);
            end
            S_EDGE_L: begin
                w_ma = MW'(w_pxv) - MW'(r_vx);
                w_mb = MW'(w_d);
            end
            S_EDGE_R: begin
                w_ma = MW'(r_ox) - MW'(r_vx);
                w_mb = MW'(w_pyv) - MW'(r_vy);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    always_comb begin
        if (r_state == S_V_CVTX) begin
            w_sum = SW'(signed'({r_cx, 30'b0})) + r_prod;
        end else begin
            w_sum = SW'(signed'({r_cy, 30'b0})) + r_prod;
        end
        w_q = w_sum[SW-1:38];
        if (w_sum[SW-1] && (w_sum[37:0] != '0)) begin
            w_q = w_q + 20'sd1;
        end
        w_v = {w_q, 8'b0};
    end

    assign w_cross = (r_vy > w_pyv) != (r_oy > w_pyv);
    assign w_hit   = !w_d[VW] ? (r_lhs < signed'(w_prod[SW-1:0]))
                              : (r_lhs > signed'(w_prod[SW-1:0]));

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[AW-1:0];
        w_wr_data = '{radius: i_req.vertex_radius, angle: i_req.vertex_angle};
        if ((r_state == S_IDLE) && w_req_acc && (i_req.req_type == REQ_APPEND)
            && (r_count != CW'(MAX_VERTICES))) begin
            w_wr_en = 1'b1;
        end else if (r_state == S_SHIFT_WR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_k[AW-1:0];
            w_wr_data = w_rd_data;
        end
    end

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_k[AW-1:0];
        if (r_state == S_SHIFT_RD) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_k[AW-1:0] + AW'(1);
        end else if (r_state == S_V_RD) begin
            w_rd_en = 1'b1;
        end
    end

    assign w_cordic_start = (r_state == S_V_TRIG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_base <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.wr_index)
                CFG_CENTER_X:   r_cx   <= signed'(i_cfg.wr_data);
                CFG_CENTER_Y:   r_cy   <= signed'(i_cfg.wr_data);
                CFG_BASE_ANGLE: r_base <= i_cfg.wr_data[ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_largest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_req_acc) begin
                        r_inside <= 1'b0;
                        r_status <= 1'b0;
                        r_px     <= i_req.point_x;
                        r_py     <= i_req.point_y;
                        r_state  <= S_DONE;
                        case (i_req.req_type)
                            REQ_APPEND: begin
                                if (r_count == CW'(MAX_VERTICES)) begin
                                    r_status <= 1'b1;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                    if (r_largest < i_req.vertex_radius) begin
                                        r_largest <= i_req.vertex_radius;
                                    end
                                end
                            end
                            REQ_REMOVE_LAST: begin
                                if (r_count == '0) begin
                                    r_status <= 1'b1;
                                end else begin
                                    r_count <= w_last;
                                end
                            end
                            REQ_REMOVE_AT: begin
                                if (w_idx_ext >= w_cnt_ext) begin
                                    r_status <= 1'b1;
                                end else begin
                                    r_k     <= w_idx_ext[CW-1:0];
                                    r_state <= S_SHIFT_RD;
                                end
                            end
                            REQ_QUERY: begin
                                if (r_count == '0) begin
                                    r_status <= 1'b1;
                                end else begin
                                    r_state <= S_FAR_DX;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SHIFT_RD: begin
                    if (r_k == w_last) begin
                        r_count <= w_last;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    r_k     <= r_k + CW'(1);
                    r_state <= S_SHIFT_RD;
                end
                S_FAR_DX: begin
                    r_acc   <= 51'(w_prod[49:0]);
                    r_state <= S_FAR_DY;
                end
                S_FAR_DY: begin
                    r_acc   <= r_acc + 51'(w_prod[49:0]);
                    r_state <= S_FAR_RR;
                end
                S_FAR_RR: begin
                    if (r_acc > 51'(w_prod[47:0])) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= w_last;
                        r_first <= 1'b1;
                        r_in    <= 1'b0;
                        r_state <= S_V_RD;
                    end
                end
                S_V_RD: begin
                    r_state <= S_V_TRIG;
                end
                S_V_TRIG: begin
                    r_rad   <= w_rd_data.radius;
                    r_state <= S_V_WAIT;
                end
                S_V_WAIT: begin
                    if (w_cordic_done) begin
                        r_cos   <= w_cos;
                        r_sin   <= w_sin;
                        r_state <= S_V_MULX;
                    end
                end
                S_V_MULX: begin
                    r_prod  <= w_prod[SW-1:0];
                    r_state <= S_V_CVTX;
                end
                S_V_CVTX: begin
                    r_vx    <= w_v;
                    r_prod  <= w_prod[SW-1:0];
                    r_state <= S_V_CVTY;
                end
                S_V_CVTY: begin
                    r_vy    <= w_v;
                    r_state <= S_EDGE_CHK;
                end
                S_EDGE_CHK: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_ox    <= r_vx;
                        r_oy    <= r_vy;
                        r_k     <= '0;
                        r_state <= S_V_RD;
                    end else if (w_cross) begin
                        r_state <= S_EDGE_L;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_EDGE_L: begin
                    r_lhs   <= w_prod[SW-1:0];
                    r_state <= S_EDGE_R;
                end
                S_EDGE_R: begin
                    if (w_hit) begin
                        r_in <= !r_in;
                    end
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_ox <= r_vx;
                    r_oy <= r_vy;
                    if (r_k == w_last) begin
                        r_inside <= r_in;
                        r_state  <= S_DONE;
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_V_RD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_inside <= r_inside;
                        r_out_status <= r_status;
                        r_out_count  <= w_cnt_out[COUNT_W-1:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.inside_res   = r_out_inside;
    assign o_res.status       = r_out_status;
    assign o_res.vertex_count = r_out_count;

endmodule
`default_nettype wire
